// ----- design/tahr_pkg.sv -----
`default_nettype none

package tahr_pkg;

  localparam int LEVEL_FRAC_BITS = 24;
  localparam int SAMPLE_BITS     = 24;
  localparam int LEN_BITS        = 24;
  localparam int STEP_BITS       = 25;
  localparam int LEVEL_BITS      = LEVEL_FRAC_BITS + 1;
  localparam int POS_BITS        = 26;
  localparam int OUT_BITS        = 26;
  localparam int OUT_BYTES_BITS  = 32;
  localparam int PROD_BITS       = SAMPLE_BITS + LEVEL_BITS + 1;
  localparam int CFG_IDX_BITS    = 3;
  localparam int CFG_DATA_BITS   = 25;

  localparam logic [LEVEL_BITS-1:0] LEVEL_ONE = LEVEL_BITS'(1) << LEVEL_FRAC_BITS;
  localparam logic [POS_BITS-1:0]   POS_MAX   = '1;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_ATTACK_LEN   = 3'd0,
    REG_HOLD_LEN     = 3'd1,
    REG_RELEASE_LEN  = 3'd2,
    REG_ATTACK_STEP  = 3'd3,
    REG_RELEASE_STEP = 3'd4,
    REG_SIG_MODE     = 3'd5
  } cfg_reg_t;

endpackage

`default_nettype wire

// ----- design/triggered_ahr_envelope_unit.sv -----
// Triggered attack-hold-release envelope, one audio sample per beat.
// Input stream: s_tdata carries the signed sample, s_tuser the trigger flag;
// a set trigger restarts the envelope at that sample and arms the block.
// Output stream: m_tdata carries the level (Q1.24), or the sample scaled by
// the level (Q3.23, floor rounding) when sig_mode is set; 0 before the first
// trigger.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data, always
// ready; write only while no beat is in flight.
// Pipeline: an accepted beat enters the middle stage, then the output register.
// Throughput: one beat per cycle while the output is not stalled. The level
// and position registers are updated in the accepting cycle, and the
// multiply sits in a second stage before the output register.
// Reset: the configuration registers return to their defaults, the envelope
// is disarmed and both stages are empty.
// Stall: when m_tready is low with m_tvalid set, the output holds, the middle stage fills and
// then s_tready drops until the output beat is taken.
`default_nettype none

module triggered_ahr_envelope_unit
  import tahr_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [CFG_IDX_BITS-1:0]   cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  wire logic                      s_tvalid,
  output logic                           s_tready,
  input  wire logic [SAMPLE_BITS-1:0]    s_tdata,   // [23:0] sample_in
  input  wire logic                      s_tuser,   // [0] trigger
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  output logic [OUT_BYTES_BITS-1:0]      m_tdata    // [25:0] sample_out
);

  logic [LEN_BITS-1:0]   attack_len;
  logic [LEN_BITS-1:0]   hold_len;
  logic [LEN_BITS-1:0]   release_len;
  logic [STEP_BITS-1:0]  attack_step;
  logic [STEP_BITS-1:0]  release_step;
  logic                  sig_mode;

  logic [POS_BITS-1:0]   position;
  logic                  armed;
  logic [LEVEL_BITS-1:0] level;

  logic                  a_valid;
  logic [LEVEL_BITS-1:0] a_level;
  logic [SAMPLE_BITS-1:0] a_sample;
  logic                  a_mode;

  logic                  advance_b;
  logic                  accept;
  logic                  armed_next;
  logic [POS_BITS-1:0]   pos_eff;
  logic [POS_BITS-1:0]   hold_end;
  logic [POS_BITS-1:0]   total;
  logic [POS_BITS-1:0]   rise;
  logic [LEVEL_BITS-1:0] fall;
  logic [LEVEL_BITS-1:0] level_next;
  logic signed [PROD_BITS-1:0] prod;
  logic [OUT_BITS-1:0]   sample_out;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      attack_len   <= LEN_BITS'(4800);
      hold_len     <= LEN_BITS'(14400);
      release_len  <= LEN_BITS'(9600);
      attack_step  <= STEP_BITS'(3495);
      release_step <= STEP_BITS'(1748);
      sig_mode     <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ATTACK_LEN:   attack_len   <= cfg_data[LEN_BITS-1:0];
        REG_HOLD_LEN:     hold_len     <= cfg_data[LEN_BITS-1:0];
        REG_RELEASE_LEN:  release_len  <= cfg_data[LEN_BITS-1:0];
        REG_ATTACK_STEP:  attack_step  <= cfg_data[STEP_BITS-1:0];
        REG_RELEASE_STEP: release_step <= cfg_data[STEP_BITS-1:0];
        REG_SIG_MODE:     sig_mode     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign advance_b = !m_tvalid || m_tready;
  assign s_tready  = !a_valid || advance_b;
  assign accept    = s_tvalid && s_tready;

  assign armed_next = armed || s_tuser;
  assign pos_eff    = s_tuser ? '0 : position;
  assign hold_end   = POS_BITS'(attack_len) + POS_BITS'(hold_len);
  assign total      = hold_end + POS_BITS'(release_len);
  assign rise       = POS_BITS'(level) + POS_BITS'(attack_step);
  assign fall       = (POS_BITS'(level) > POS_BITS'(release_step))
                      ? (level - LEVEL_BITS'(release_step)) : '0;

  always_comb begin
    if (!armed_next) begin
      level_next = '0;
    end else if (pos_eff < POS_BITS'(attack_len)) begin
      level_next = (rise > POS_BITS'(LEVEL_ONE)) ? LEVEL_ONE : rise[LEVEL_BITS-1:0];
    end else if (pos_eff < hold_end) begin
      level_next = LEVEL_ONE;
    end else if (pos_eff < total) begin
      level_next = fall;
    end else begin
      level_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
      armed    <= 1'b0;
      level    <= '0;
      a_valid  <= 1'b0;
    end else begin
      if (accept) begin
        armed <= armed_next;
        if (armed_next) begin
          position <= (pos_eff < POS_MAX) ? pos_eff + POS_BITS'(1) : pos_eff;
          level    <= level_next;
        end
        a_valid <= 1'b1;
      end else if (advance_b) begin
        a_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_level  <= level_next;
      a_sample <= s_tdata;
      a_mode   <= sig_mode;
    end
  end

  assign prod = $signed({{(PROD_BITS-SAMPLE_BITS){a_sample[SAMPLE_BITS-1]}}, a_sample})
              * $signed({{(PROD_BITS-LEVEL_BITS){1'b0}}, a_level});

  assign sample_out = a_mode ? prod[LEVEL_FRAC_BITS+OUT_BITS-1:LEVEL_FRAC_BITS]
                             : OUT_BITS'(a_level);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance_b) begin
      m_tvalid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance_b && a_valid) begin
      m_tdata <= OUT_BYTES_BITS'(sample_out);
    end
  end

endmodule

`default_nettype wire

// ----- sim/tb_triggered_ahr_envelope_unit.sv -----
`timescale 1ns / 1ps

module tb_triggered_ahr_envelope_unit;
  import tahr_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int PLAN_ROWS   = 26;

  typedef struct packed {
    logic                      is_cfg;
    cfg_reg_t                  idx;
    logic [CFG_DATA_BITS-1:0]  value;
    logic                      trig;
    logic [SAMPLE_BITS-1:0]    smp;
    logic                      typed;
    logic [OUT_BYTES_BITS-1:0] beat;
  } plan_row_t;

  logic                      clk;
  logic                      rst;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_IDX_BITS-1:0]   cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;
  logic                      s_tvalid;
  logic                      s_tready;
  logic [SAMPLE_BITS-1:0]    s_tdata;   // [23:0] sample_in
  logic                      s_tuser;   // [0] trigger
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  logic [OUT_BYTES_BITS-1:0] m_tdata;   // [25:0] sample_out

  logic [LEN_BITS-1:0]       atk_len;
  logic [LEN_BITS-1:0]       hld_len;
  logic [LEN_BITS-1:0]       rel_len;
  logic [STEP_BITS-1:0]      atk_step;
  logic [STEP_BITS-1:0]      rel_step;
  logic                      sig_mode;
  logic [POS_BITS-1:0]       env_pos;
  logic                      env_armed;
  logic [LEVEL_BITS-1:0]     env_level;

  logic [OUT_BYTES_BITS-1:0] pending_beats[$];
  logic [OUT_BYTES_BITS-1:0] expected_beat;
  int                        errors = 0;
  int                        gap_pct = 31;
  int                        stall_pct = 52;
  int                        idle_cycles = 0;

  plan_row_t plan [PLAN_ROWS] = '{
    '{1'b0, REG_ATTACK_LEN,   25'h0,       1'b0, 24'h7FFFFF, 1'b1, 32'h00000000},
    '{1'b0, REG_ATTACK_LEN,   25'h0,       1'b0, 24'h800000, 1'b1, 32'h00000000},
    '{1'b1, REG_ATTACK_LEN,   25'd2,       1'b0, 24'h0,      1'b0, 32'h0},
    '{1'b1, REG_HOLD_LEN,     25'd1,       1'b0, 24'h0,      1'b0, 32'h0},
    '{1'b1, REG_RELEASE_LEN,  25'd1,       1'b0, 24'h0,      1'b0, 32'h0},
    '{1'b1, REG_ATTACK_STEP,  25'h1FFFFFF, 1'b0, 24'h0,      1'b0, 32'h0},
    '{1'b1, REG_RELEASE_STEP, 25'h1000000, 1'b0, 24'h0,      1'b0, 32'h0},
    '{1'b0, REG_ATTACK_LEN,   25'h0,       1'b1, 24'h000000, 1'b1, 32'h01000000},
    '{1'b0, REG_ATTACK_LEN,   25'h0,       1'b0, 24'h123456, 1'b1, 32'h01000000},
    '{1'b0, REG_ATTACK_LEN,   25'h0,       1'b0, 24'h000000, 1'b1, 32'h01000000},
    '{1'b0, REG_ATTACK_LEN,   25'h0,       1'b0, 24'h000000, 1'b1, 32'h00000000},
    '{1'b0, REG_ATTACK_LEN,   25'h0,       1'b0, 24'hFFFFFF, 1'b1, 32'h00000000},
    '{1'b1, REG_SIG_MODE,     25'd1,       1'b0, 24'h0,      1'b0, 32'h0},
    '{1'b0, REG_ATTACK_LEN,   25'h0,       1'b1, 24'h7FFFFF, 1'b1, 32'h007FFFFF},
    '{1'b0, REG_ATTACK_LEN,   25'h0,       1'b0, 24'h800000, 1'b1, 32'h03800000},
    '{1'b0, REG_ATTACK_LEN,   25'h0,       1'b0, 24'h7FFFFF, 1'b1, 32'h007FFFFF},
    '{1'b0, REG_ATTACK_LEN,   25'h0,       1'b0, 24'h800000, 1'b1, 32'h00000000},
    '{1'b1, REG_ATTACK_LEN,   25'd0,       1'b0, 24'h0,      1'b0, 32'h0},
    '{1'b1, REG_HOLD_LEN,     25'd0,       1'b0, 24'h0,      1'b0, 32'h0},
    '{1'b1, REG_RELEASE_LEN,  25'd0,       1'b0, 24'h0,      1'b0, 32'h0},
    '{1'b0, REG_ATTACK_LEN,   25'h0,       1'b1, 24'h7FFFFF, 1'b1, 32'h00000000},
    '{1'b1, REG_ATTACK_LEN,   25'hFFFFFF,  1'b0, 24'h0,      1'b0, 32'h0},
    '{1'b1, REG_ATTACK_STEP,  25'd1,       1'b0, 24'h0,      1'b0, 32'h0},
    '{1'b0, REG_ATTACK_LEN,   25'h0,       1'b1, 24'hFFFFFF, 1'b1, 32'h03FFFFFF},
    '{1'b0, REG_ATTACK_LEN,   25'h0,       1'b0, 24'h7FFFFF, 1'b0, 32'h0},
    '{1'b0, REG_ATTACK_LEN,   25'h0,       1'b1, 24'h000001, 1'b0, 32'h0}
  };

  triggered_ahr_envelope_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void reset_envelope();
    atk_len   = 24'd4800;
    hld_len   = 24'd14400;
    rel_len   = 24'd9600;
    atk_step  = 25'd3495;
    rel_step  = 25'd1748;
    sig_mode  = 1'b0;
    env_pos   = '0;
    env_armed = 1'b0;
    env_level = '0;
  endfunction

  function automatic void apply_reg(input cfg_reg_t idx, input logic [CFG_DATA_BITS-1:0] val);
    case (idx)
      REG_ATTACK_LEN:   atk_len  = val[LEN_BITS-1:0];
      REG_HOLD_LEN:     hld_len  = val[LEN_BITS-1:0];
      REG_RELEASE_LEN:  rel_len  = val[LEN_BITS-1:0];
      REG_ATTACK_STEP:  atk_step = val[STEP_BITS-1:0];
      REG_RELEASE_STEP: rel_step = val[STEP_BITS-1:0];
      REG_SIG_MODE:     sig_mode = val[0];
      default: ;
    endcase
  endfunction

  function automatic logic [OUT_BYTES_BITS-1:0] envelope_beat(input logic trig,
                                                              input logic [SAMPLE_BITS-1:0] smp);
    longint unsigned hold_end;
    longint unsigned total;
    longint unsigned lvl;
    longint          prod;
    logic [OUT_BITS-1:0] res;
    hold_end = 64'(atk_len) + 64'(hld_len);
    total    = hold_end + 64'(rel_len);
    if (trig) begin
      env_pos   = '0;
      env_armed = 1'b1;
    end
    if (!env_armed) return '0;
    if (env_pos < POS_BITS'(atk_len)) begin
      lvl = 64'(env_level) + 64'(atk_step);
      if (lvl > 64'(LEVEL_ONE)) lvl = 64'(LEVEL_ONE);
    end else if (64'(env_pos) < hold_end) begin
      lvl = 64'(LEVEL_ONE);
    end else if (64'(env_pos) < total) begin
      lvl = (env_level > rel_step) ? 64'(env_level) - 64'(rel_step) : 64'd0;
    end else begin
      lvl = 64'd0;
    end
    if (sig_mode) begin
      prod = longint'($signed(smp)) * longint'(lvl);
      res  = OUT_BITS'(prod >>> LEVEL_FRAC_BITS);
    end else begin
      res = OUT_BITS'(lvl);
    end
    if (env_pos != POS_MAX) env_pos = env_pos + POS_BITS'(1);
    env_level = LEVEL_BITS'(lvl);
    return OUT_BYTES_BITS'(res);
  endfunction

  function automatic logic [CFG_DATA_BITS-1:0] random_reg(input cfg_reg_t idx);
    case (idx)
      REG_ATTACK_LEN, REG_HOLD_LEN, REG_RELEASE_LEN:
        return ($urandom_range(9) == 0) ? CFG_DATA_BITS'(24'hFFFFFF)
                                        : CFG_DATA_BITS'($urandom_range(12));
      REG_SIG_MODE:
        return CFG_DATA_BITS'($urandom_range(1));
      default:
        case ($urandom_range(5))
          0:       return '0;
          1:       return CFG_DATA_BITS'(LEVEL_ONE);
          2:       return '1;
          default: return CFG_DATA_BITS'($urandom_range(32'h400000, 1));
        endcase
    endcase
  endfunction

  task automatic wait_for_results();
    while (pending_beats.size() != 0) @(negedge clk);
  endtask

  task automatic cfg_write(input cfg_reg_t idx, input logic [CFG_DATA_BITS-1:0] val);
    wait_for_results();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, val);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic push_beat(input logic trig, input logic [SAMPLE_BITS-1:0] smp,
                           input logic typed, input logic [OUT_BYTES_BITS-1:0] beat);
    logic [OUT_BYTES_BITS-1:0] predicted;
    while ($urandom_range(99) < gap_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = smp;
    s_tuser  = trig;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = envelope_beat(trig, smp);
    pending_beats.push_back(typed ? beat : predicted);
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  task automatic run_block(input int n, input int kind);
    logic [CFG_DATA_BITS-1:0] val;
    logic [SAMPLE_BITS-1:0]   smp;
    logic                     trig;
    for (int r = 0; r < 6; r++) begin
      case (kind)
        0:       val = '1;
        1:       val = '0;
        default: val = random_reg(cfg_reg_t'(r));
      endcase
      cfg_write(cfg_reg_t'(r), val);
    end
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) smp = $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
      else smp = SAMPLE_BITS'($urandom);
      trig = (i == 0 && $urandom_range(3) != 0) || $urandom_range(24) == 0;
      push_beat(trig, smp, 1'b0, '0);
    end
  endtask

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (pending_beats.size() == 0) begin
          errors++;
          $display("%0t: unexpected output beat, expected none, got %h", $time, m_tdata);
        end else begin
          expected_beat = pending_beats.pop_front();
          if (m_tdata !== expected_beat) begin
            errors++;
            $display("%0t: sample_out mismatch, expected %h, got %h",
                     $time, expected_beat, m_tdata);
          end
        end
      end
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("[FAIL] regression broken");
          $finish;
        end
      end
    end
  end

  initial begin
    rst       = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = 1'b0;
    reset_envelope();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int k = 0; k < PLAN_ROWS; k++) begin
      if (plan[k].is_cfg) cfg_write(plan[k].idx, plan[k].value);
      else push_beat(plan[k].trig, plan[k].smp, plan[k].typed, plan[k].beat);
    end

    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          gap_pct   = 31;
          stall_pct = 52;
        end
        1: begin
          gap_pct   = 52;
          stall_pct = 31;
        end
        default: begin
          gap_pct   = 0;
          stall_pct = 0;
        end
      endcase
      for (int b = 0; b < 3; b++) begin
        run_block(60, 3 * mode + b);
      end
    end

    wait_for_results();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
